// ===== design/bol_pkg.sv =====
// Package for the bounded ordered list: command, status and state codes,
// the result record and fixed field widths. No dependencies.

package bol_pkg;

  // Fixed field widths and list limits.
  localparam int CfgW       = 5;
  localparam int ValW       = 32;
  localparam int MaxResults = 16;

  // Command codes carried by cmd_i; codes 5 to 7 are unused.
  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_HEAD   = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_CHECK  = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_HEAD,
    S_LIST,
    S_RESP
  } state_e;

  // One result item as it moves into the output register.
  typedef struct packed {
    status_e               status;
    logic signed [ValW-1:0] data;
    logic                  empty;
    logic                  last;
  } res_t;

endpackage

// ===== design/bounded_ordered_list_core.sv =====
// Top level of the bounded ordered list: a sequencer around one entry memory
// and an output register. Depends on bol_pkg and bol_out_reg.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  -------------------------------------
//   in       in_valid_i / in_ready_o  cmd_i, value_i
//   out      out_valid_o / out_ready_i status_o, data_o, empty_flag_o, last_o
//   cfg      cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// Append, check empty and unused commands update the state in the accepting
// cycle and load the result from S_RESP. Read head reads the memory, then loads
// the entry from S_HEAD. Remove reads one entry per cycle while searching and
// moves one entry per cycle while closing the gap; list delivers one entry per
// cycle while the output register is free. The registered read port of the
// entry memory sets this pacing. Reset clears the count and capacity; the
// memory needs no clearing.
// A stalled output holds the sequencer in place, and a new item is taken
// while the last result still waits.

module bounded_ordered_list_core import bol_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             cmd_i,
  input  logic signed [ValW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic signed [ValW-1:0] data_o,
  output logic                   empty_flag_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgW-1:0]        cfg_data_i
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int LW      = (CW > CfgW) ? CW : CfgW;
  localparam int ListMax = (DEPTH < MaxResults) ? DEPTH : MaxResults;
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);
  localparam logic [CW-1:0] ListMaxC = CW'(ListMax);

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CfgW-1:0]        capacity_q;
  logic signed [ValW-1:0] value_q, value_d;
  status_e                resp_status_q, resp_status_d;
  logic signed [ValW-1:0] resp_data_q, resp_data_d;

  // Entry memory with a registered read port.
  logic [ValW-1:0]        mem_q [DEPTH];
  logic [ValW-1:0]        rdata_q;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [ValW-1:0]        mem_wdata;

  logic                   out_free, push;
  res_t                   res, out_res;

  logic                   full, is_empty;
  logic [CW:0]            idx_nx, idx_nx2, cnt_x, list_n;

  // Capacity register; a write is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // List limits and index arithmetic one bit wider than the count.
  assign is_empty = (count_q == '0);
  assign full     = (LW'(count_q) >= LW'(capacity_q)) || (count_q == DepthC);
  assign cnt_x    = {1'b0, count_q};
  assign idx_nx   = {1'b0, idx_q} + (CW + 1)'(1);
  assign idx_nx2  = idx_nx + (CW + 1)'(1);
  assign list_n   = {1'b0, (count_q < ListMaxC) ? count_q : ListMaxC};

  // Sequencer: next state, memory accesses and result pushes.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    value_d       = value_q;
    resp_status_d = resp_status_q;
    resp_data_d   = resp_data_q;
    mem_we        = 1'b0;
    mem_waddr     = count_q[AW-1:0];
    mem_wdata     = value_i;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    in_ready_o    = 1'b0;
    push          = 1'b0;
    res.status    = STATUS_OK;
    res.data      = '0;
    res.empty     = is_empty;
    res.last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          value_d       = value_i;
          resp_status_d = STATUS_OK;
          resp_data_d   = '0;
          idx_d         = '0;
          state_d       = S_RESP;
          case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              if (full) begin
                resp_status_d = STATUS_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_REMOVE: begin
              if (is_empty) begin
                resp_status_d = STATUS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                state_d = S_SEARCH;
              end
            end
            CMD_HEAD: begin
              if (is_empty) begin
                resp_status_d = STATUS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                state_d = S_HEAD;
              end
            end
            CMD_LIST: begin
              if (is_empty) begin
                resp_status_d = STATUS_EMPTY;
              end else begin
                mem_re  = 1'b1;
                state_d = S_LIST;
              end
            end
            CMD_CHECK: begin
              resp_status_d = is_empty ? STATUS_EMPTY : STATUS_OK;
            end
            default: begin
              resp_status_d = STATUS_OK;
            end
          endcase
        end
      end

      // The entry at idx_q is in rdata_q; compare and step on.
      S_SEARCH: begin
        if (rdata_q == value_q) begin
          if (idx_nx < cnt_x) begin
            mem_re    = 1'b1;
            mem_raddr = idx_nx[AW-1:0];
            state_d   = S_SHIFT;
          end else begin
            count_d       = count_q - CW'(1);
            resp_status_d = STATUS_OK;
            resp_data_d   = value_q;
            state_d       = S_RESP;
          end
        end else if (idx_nx >= cnt_x) begin
          resp_status_d = STATUS_NOTFOUND;
          state_d       = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_nx[AW-1:0];
          idx_d     = idx_nx[CW-1:0];
        end
      end

      // The entry after idx_q is in rdata_q; move it up one place. The read
      // and the write never hit the same entry, so no forwarding is needed.
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
        if (idx_nx2 < cnt_x) begin
          mem_re    = 1'b1;
          mem_raddr = idx_nx2[AW-1:0];
          idx_d     = idx_nx[CW-1:0];
        end else begin
          count_d       = count_q - CW'(1);
          resp_status_d = STATUS_OK;
          resp_data_d   = value_q;
          state_d       = S_RESP;
        end
      end

      S_HEAD: begin
        if (out_free) begin
          push     = 1'b1;
          res.data = rdata_q;
          state_d  = S_IDLE;
        end
      end

      // One listed entry per transfer; the next read is issued with it.
      S_LIST: begin
        if (out_free) begin
          push     = 1'b1;
          res.data = rdata_q;
          res.last = (idx_nx >= list_n);
          if (idx_nx >= list_n) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_nx[AW-1:0];
            idx_d     = idx_nx[CW-1:0];
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          push       = 1'b1;
          res.status = resp_status_q;
          res.data   = resp_data_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Item payload and pending single result.
  always_ff @(posedge clk_i) begin
    value_q       <= value_d;
    resp_status_q <= resp_status_d;
    resp_data_q   <= resp_data_d;
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Memory read port, registered.
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Output register.
  bol_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign status_o     = out_res.status;
  assign data_o       = out_res.data;
  assign empty_flag_o = out_res.empty;
  assign last_o       = out_res.last;

  // The count never passes the memory depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count exceeds depth");

  // The count moves by at most one entry between edges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");

  // Only a listing produces a result that is not the final one of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !res.last) |-> (state_q == S_LIST))
    else $error("non-final result outside a listing");

  // A shift only writes inside the occupied part of the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_SHIFT) |-> (idx_nx < cnt_x))
    else $error("shift writes beyond the tail");

endmodule

// ===== design/bol_out_reg.sv =====
// Output register of the bounded ordered list: holds one result until the
// downstream side takes it. Depends on bol_pkg.

module bol_out_reg import bol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic free_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // The slot can take a new result when it is empty or drains this cycle.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload, loaded on each push.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== verif/bounded_ordered_list_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for bounded_ordered_list_core: directed and random command streams,
// checked result by result against a list model kept in the bench.
// Depends on bol_pkg and the bounded_ordered_list_core RTL.

module bounded_ordered_list_core_tb import bol_pkg::*; ();

  localparam int Depth = 16;
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 24;
  localparam logic [2:0] CmdMax = 3'd7;
  localparam logic [ValW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValW-1:0] ValMax = 32'h7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] cmd_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic signed [ValW-1:0] data_o;
  logic empty_flag_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgW-1:0] cfg_data_i = '0;

  // Shadow copy of the list contents and the capacity register.
  logic signed [ValW-1:0] shadow_entries [Depth];
  int unsigned shadow_count = 0;
  logic [CfgW-1:0] shadow_capacity = '0;
  res_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 25;
  bit hold_pending = 1'b0;

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bounded_ordered_list_core #(
    .DEPTH(Depth)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .empty_flag_o(empty_flag_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Queue one expected result; the empty flag reflects the list after the step.
  function automatic void push_result(status_e st, logic signed [ValW-1:0] d, logic lst);
    res_t r;
    r.status = st;
    r.data = d;
    r.empty = (shadow_count == 0);
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one command to the shadow list and queue the results it causes.
  function automatic void apply_list_command(logic [2:0] cmd, logic signed [ValW-1:0] val);
    int unsigned lim;
    int unsigned pos;
    int unsigned n;
    int unsigned k;
    lim = (shadow_capacity < Depth) ? shadow_capacity : Depth;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_count >= lim) begin
          push_result(STATUS_FULL, '0, 1'b1);
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
          push_result(STATUS_OK, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          push_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_entries[pos] != val) pos++;
          if (pos == shadow_count) begin
            push_result(STATUS_NOTFOUND, '0, 1'b1);
          end else begin
            for (k = pos; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k + 1];
            shadow_count--;
            push_result(STATUS_OK, val, 1'b1);
          end
        end
      end
      CMD_HEAD: begin
        if (shadow_count == 0) begin
          push_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          push_result(STATUS_OK, shadow_entries[0], 1'b1);
        end
      end
      CMD_LIST: begin
        if (shadow_count == 0) begin
          push_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          n = (shadow_count < MaxResults) ? shadow_count : MaxResults;
          for (k = 0; k < n; k++) push_result(STATUS_OK, shadow_entries[k], k + 1 == n);
        end
      end
      CMD_CHECK: begin
        push_result((shadow_count == 0) ? STATUS_EMPTY : STATUS_OK, '0, 1'b1);
      end
      default: begin
        push_result(STATUS_OK, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Check each result transfer, then track config and input transfers.
  always @(posedge clk_i) begin : result_check
    res_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          report_mismatch("result with none pending", data_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (data_o !== want.data) report_mismatch("data", data_o, want.data);
          if (empty_flag_o !== want.empty)
            report_mismatch("empty_flag", 32'(empty_flag_o), 32'(want.empty));
          if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        shadow_capacity = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        apply_list_command(cmd_i, value_i);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Result-side ready: random gaps, plus one long hold-off on request.
  initial begin : sink_pacing
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready_i <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(posedge clk_i);
          held++;
        end
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // End the run when no transfer of any kind happens for too long.
  initial begin : stall_watchdog
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("timeout: no transfer for %0d cycles", StallLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one command; valid stays high after the transfer until the next call or wait_until_idle.
  task automatic send_command(logic [2:0] cmd, logic signed [ValW-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait until every expected result has arrived and the sequencer has settled.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CfgW-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly a small pool so removals find duplicates, with extremes and noise.
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return ValW'($urandom_range(0, 7)) - 4;
    if (r < 8) begin
      case ($urandom_range(3))
        0: return ValMin;
        1: return ValMax;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // One phase of random commands at a given capacity.
  task automatic run_random_phase(logic [CfgW-1:0] cap, int unsigned items,
                                  int unsigned append_pct);
    int unsigned i;
    int unsigned r;
    logic [2:0] cmd;
    logic signed [ValW-1:0] val;
    wait_until_idle();
    write_capacity(cap);
    for (i = 0; i < items; i++) begin
      val = pick_value();
      if ($urandom_range(99) < append_pct) begin
        cmd = CMD_APPEND;
      end else begin
        r = $urandom_range(19);
        if (r < 8) begin
          cmd = CMD_REMOVE;
          if (shadow_count != 0 && $urandom_range(9) < 7)
            val = shadow_entries[$urandom_range(0, shadow_count - 1)];
        end else if (r < 11) begin
          cmd = CMD_HEAD;
        end else if (r < 14) begin
          cmd = CMD_LIST;
        end else if (r < 17) begin
          cmd = CMD_CHECK;
        end else begin
          cmd = 3'($urandom_range(CMD_CHECK + 1, CmdMax));
        end
      end
      send_command(cmd, val);
    end
  endtask

  // Every command on an empty list, with the capacity still at its reset value.
  task automatic test_empty_list();
    logic [3:0] code;
    send_command(CMD_APPEND, 32'sd5);
    send_command(CMD_REMOVE, 32'sd5);
    send_command(CMD_HEAD, $urandom);
    send_command(CMD_LIST, $urandom);
    send_command(CMD_CHECK, $urandom);
    for (code = 4'(CMD_CHECK) + 4'd1; code <= 4'(CmdMax); code++)
      send_command(code[2:0], $urandom);
  endtask

  // Fill a small list with extreme values, refuse an append, remove from the middle,
  // the head and the tail, and lower the capacity below the count.
  task automatic test_small_capacity();
    wait_until_idle();
    write_capacity(5'd3);
    send_command(CMD_APPEND, ValMin);
    send_command(CMD_APPEND, ValMax);
    send_command(CMD_APPEND, '1);
    send_command(CMD_APPEND, '0);
    send_command(CMD_LIST, '0);
    send_command(CMD_HEAD, '0);
    send_command(CMD_REMOVE, ValMax);
    send_command(CMD_REMOVE, 32'sd12345);
    send_command(CMD_REMOVE, ValMin);
    send_command(CMD_APPEND, '0);
    wait_until_idle();
    write_capacity(5'd1);
    send_command(CMD_APPEND, 32'sd1);
    send_command(CMD_CHECK, '0);
    send_command(CMD_REMOVE, '0);
    send_command(CMD_LIST, '0);
  endtask

  // Random phases over several capacities, one of them without any idling.
  task automatic test_random_traffic();
    run_random_phase(5'd16, 60, 55);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(5'd31, 70, 60);
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    run_random_phase(5'd5, 50, 45);
    run_random_phase(5'd0, 30, 40);
    run_random_phase(5'd1, 40, 45);
    run_random_phase(5'($urandom_range(0, 31)), 60, 50);
  endtask

  // Fill the list, then hold the result side off while lists keep coming in.
  task automatic test_output_backpressure();
    int unsigned i;
    wait_until_idle();
    write_capacity(5'd16);
    for (i = 0; i < 16; i++) send_command(CMD_APPEND, pick_value());
    hold_pending = 1'b1;
    for (i = 0; i < 24; i++) send_command(($urandom_range(3) == 0) ? CMD_HEAD : CMD_LIST, '0);
  endtask

  initial begin : test_sequence
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_small_capacity();
    test_random_traffic();
    test_output_backpressure();
    wait_until_idle();
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== bounded_ordered_list_core.f =====
design/bol_pkg.sv
design/bol_out_reg.sv
design/bounded_ordered_list_core.sv
verif/bounded_ordered_list_core_tb.sv
